>>> hw/rtl/haar2d_pkg.sv
// ============================================================================
// haar2d_pkg
// Shared constants and types of the 2D Haar analysis block.
// ============================================================================
package haar2d_pkg;

  localparam int CFG_W      = 13;    // width of the frame size registers
  localparam int ROW_W      = 12;    // row counter, rows 0..4095
  localparam int CMP_W      = 15;    // wide enough for any column limit plus one
  localparam int BCOL_W     = 11;
  localparam int BROW_W     = 11;
  localparam int MAX_HEIGHT = 4096;
  localparam int RST_WIDTH  = 64;
  localparam int RST_HEIGHT = 64;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Control that travels with one pixel pair from the pairing stage.
  typedef struct packed {
    logic              emit;
    logic              odd_row;
    logic [BCOL_W-1:0] block_col;
    logic [BROW_W-1:0] block_row;
    logic              last_block;
  } blk_ctl_t;

  // Status of the combine stage as seen by the top level.
  typedef struct packed {
    logic s1_valid;
    logic ready;
  } stage_stat_t;

endpackage

>>> hw/rtl/haar_2d_analysis.sv
// ============================================================================
// haar_2d_analysis
// Single-level 2D Haar analysis of a raster pixel stream, one block per 2x2.
// ============================================================================
// Pixels enter on s_axis in raster order, one per transfer. For every 2x2
// block one result leaves on m_axis holding the approximation (a four-pixel
// sum) and the horizontal, vertical and diagonal details (signed four-pixel
// combinations), the block column and row, and tlast on the final block of
// the frame. Odd widths and heights pair the last column or row with itself.
// Frame size is set through the write port (index 0 width, index 1 height);
// a write restarts the frame and may only be issued while the block is idle.
// Throughput is one pixel per cycle while m_axis is not stalled. m_axis_tvalid
// rises once the result register is loaded for the block: the transfer of
// the pixel that completes the block loads the pairing register and reads
// the line memory, and the result register is loaded from them after that.
// The even-row pairs sit in a single-port line memory of (MAX_WIDTH+1)/2
// words; each pixel uses it at most once. Reset clears the position
// counters, the held pixel and all valid flags, and sets a 64x64 frame; the
// line memory needs no clearing. When m_axis stalls, the result register and
// one pair in flight are held, and s_axis_tready drops only after that.
module haar_2d_analysis import haar2d_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int SUM_W       = PIXEL_BITS + 1,
  localparam int OUT_W       = PIXEL_BITS + 2,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_PAY_W   = 4 * OUT_W + BCOL_W + BROW_W,
  localparam int OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8,
  localparam int LINE_DEPTH  = (MAX_WIDTH + 1) / 2,
  localparam int AW          = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pixel
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // approx, horiz_detail, vert_detail, diag_detail, block_col, block_row
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast   // last_block
);

  logic                    in_fire;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_addr;
  logic [2*SUM_W-1:0]      ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0] pair_sum, pair_dif;
  blk_ctl_t                pair_ctl;
  stage_stat_t             stat;
  logic signed [OUT_W-1:0] approx, horiz, vert, diag;
  logic [BCOL_W-1:0]       block_col;
  logic [BROW_W-1:0]       block_row;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = stat.ready;

  haar2d_pair #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_pair (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_fire_i   (in_fire),
    .pixel_i     ($signed(s_axis_tdata[PIXEL_BITS-1:0])),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .sum_o       (pair_sum),
    .dif_o       (pair_dif),
    .ctl_o       (pair_ctl)
  );

  haar2d_ram #(
    .WIDTH (2 * SUM_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  haar2d_combine #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_combine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .sum_i        (pair_sum),
    .dif_i        (pair_dif),
    .ctl_i        (pair_ctl),
    .line_i       (ram_rdata),
    .out_ready_i  (m_axis_tready),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .approx_o     (approx),
    .horiz_o      (horiz),
    .vert_o       (vert),
    .diag_o       (diag),
    .block_col_o  (block_col),
    .block_row_o  (block_row),
    .last_block_o (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_W'({block_row, block_col, diag, vert, horiz, approx});

`ifndef ASSERT_OFF
  // The line memory port is either written or read for one pixel, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("line memory written and read in the same cycle");

  // A result only appears after a block has been held in stage 1.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stat.s1_valid))
    else $error("result raised without a pending block");

  // A pixel is taken into a full stage 1 only while stage 1 drains.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && stat.s1_valid && pair_ctl.emit |-> !m_axis_tvalid || m_axis_tready)
    else $error("pixel accepted over a stalled block");
`endif

endmodule

>>> hw/rtl/haar2d_ram.sv
// ============================================================================
// haar2d_ram
// Generic single-port RAM with a registered read.
// ============================================================================
module haar2d_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/haar2d_pair.sv
// ============================================================================
// haar2d_pair
// Raster position tracking, horizontal pairing and line memory control.
// ============================================================================
module haar2d_pair import haar2d_pkg::*; #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16,
  localparam int COL_W      = $clog2(MAX_WIDTH),
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2,
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1,
  localparam int SUM_W      = PIXEL_BITS + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_fire_i,
  input  logic signed [PIXEL_BITS-1:0] pixel_i,
  output logic                    ram_we_o,
  output logic                    ram_re_o,
  output logic [AW-1:0]           ram_addr_o,
  output logic [2*SUM_W-1:0]      ram_wdata_o,
  output logic signed [SUM_W-1:0] sum_o,
  output logic signed [SUM_W-1:0] dif_o,
  output blk_ctl_t                ctl_o
);

  logic [CFG_W-1:0]      width_q, height_q;
  logic [CFG_W-1:0]      width_clamp, height_clamp;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic signed [PIXEL_BITS-1:0] held_q;
  logic signed [SUM_W-1:0] pix_x, held_x, sum_d, dif_d;
  logic                  col_last, row_last, have_pair, hold_pix;
  blk_ctl_t              ctl_d;
  logic signed [SUM_W-1:0] sum_q, dif_q;
  blk_ctl_t              ctl_q;

  // Saturate written sizes to the legal range.
  always_comb begin
    if (cfg_data_i == '0) begin
      width_clamp = CFG_W'(1);
    end else if (CMP_W'(cfg_data_i) > CMP_W'(MAX_WIDTH)) begin
      width_clamp = CFG_W'(MAX_WIDTH);
    end else begin
      width_clamp = cfg_data_i;
    end
    if (cfg_data_i == '0) begin
      height_clamp = CFG_W'(1);
    end else if (CMP_W'(cfg_data_i) > CMP_W'(MAX_HEIGHT)) begin
      height_clamp = CFG_W'(MAX_HEIGHT);
    end else begin
      height_clamp = cfg_data_i;
    end
  end

  always_comb begin
    col_last  = (CMP_W'(col_q) + CMP_W'(1)) == CMP_W'(width_q);
    row_last  = (CFG_W'(row_q) + CFG_W'(1)) == height_q;
    pix_x     = SUM_W'(pixel_i);
    held_x    = SUM_W'(held_q);
    have_pair = 1'b1;
    hold_pix  = 1'b0;
    sum_d     = pix_x + pix_x;
    dif_d     = '0;
    if (col_q[0]) begin
      sum_d = held_x + pix_x;
      dif_d = held_x - pix_x;
    end else if (!col_last) begin
      have_pair = 1'b0;
      hold_pix  = 1'b1;
    end

    // An odd row always combines with the stored even-row pair; the last
    // row of an odd-height frame pairs with itself and skips the memory.
    ctl_d.emit       = have_pair && (row_q[0] || row_last);
    ctl_d.odd_row    = row_q[0];
    ctl_d.block_col  = BCOL_W'(col_q >> 1);
    ctl_d.block_row  = BROW_W'(row_q >> 1);
    ctl_d.last_block = col_last && row_last;

    col_d = col_last ? '0 : col_q + COL_W'(1);
    row_d = row_q;
    if (col_last) begin
      row_d = row_last ? '0 : row_q + ROW_W'(1);
    end
  end

  assign ram_we_o    = in_fire_i && have_pair && !row_q[0] && !row_last;
  assign ram_re_o    = in_fire_i && have_pair && row_q[0];
  assign ram_addr_o  = AW'(col_q >> 1);
  assign ram_wdata_o = {dif_d, sum_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RST_WIDTH);
      height_q <= CFG_W'(RST_HEIGHT);
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= width_clamp;
        REG_FRAME_HEIGHT: height_q <= height_clamp;
      endcase
      col_q  <= '0;
      row_q  <= '0;
      held_q <= '0;
    end else if (in_fire_i) begin
      col_q <= col_d;
      row_q <= row_d;
      if (hold_pix) begin
        held_q <= pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      sum_q <= sum_d;
      dif_q <= dif_d;
      ctl_q <= ctl_d;
    end
  end

  assign sum_o = sum_q;
  assign dif_o = dif_q;
  assign ctl_o = ctl_q;

endmodule

>>> hw/rtl/haar2d_combine.sv
// ============================================================================
// haar2d_combine
// Vertical combination of row pairs and the result register.
// ============================================================================
module haar2d_combine import haar2d_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  localparam int SUM_W     = PIXEL_BITS + 1,
  localparam int OUT_W     = PIXEL_BITS + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_fire_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic signed [SUM_W-1:0] dif_i,
  input  blk_ctl_t                ctl_i,
  input  logic [2*SUM_W-1:0]      line_i,
  input  logic                    out_ready_i,
  output stage_stat_t             stat_o,
  output logic                    out_valid_o,
  output logic signed [OUT_W-1:0] approx_o,
  output logic signed [OUT_W-1:0] horiz_o,
  output logic signed [OUT_W-1:0] vert_o,
  output logic signed [OUT_W-1:0] diag_o,
  output logic [BCOL_W-1:0]       block_col_o,
  output logic [BROW_W-1:0]       block_row_o,
  output logic                    last_block_o
);

  logic                    s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic                    out_free, s1_move, load;
  logic signed [SUM_W-1:0] sum0, dif0;
  logic signed [OUT_W-1:0] a_d, h_d, v_d, g_d;
  logic signed [OUT_W-1:0] a_q, h_q, v_q, g_q;
  logic [BCOL_W-1:0]       bcol_q;
  logic [BROW_W-1:0]       brow_q;
  logic                    last_q;

  // A pair that produces no block leaves stage 1 without waiting on the output.
  assign out_free = !out_valid_q || out_ready_i;
  assign s1_move  = s1_valid_q && (!ctl_i.emit || out_free);
  assign load     = s1_valid_q && ctl_i.emit && out_free;

  assign s1_valid_d  = in_fire_i ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  assign sum0 = line_i[SUM_W-1:0];
  assign dif0 = line_i[2*SUM_W-1:SUM_W];

  always_comb begin
    if (ctl_i.odd_row) begin
      a_d = OUT_W'(sum0) + OUT_W'(sum_i);
      v_d = OUT_W'(sum0) - OUT_W'(sum_i);
      h_d = OUT_W'(dif0) + OUT_W'(dif_i);
      g_d = OUT_W'(dif0) - OUT_W'(dif_i);
    end else begin
      a_d = OUT_W'(sum_i) + OUT_W'(sum_i);
      h_d = OUT_W'(dif_i) + OUT_W'(dif_i);
      v_d = '0;
      g_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      a_q    <= a_d;
      h_q    <= h_d;
      v_q    <= v_d;
      g_q    <= g_d;
      bcol_q <= ctl_i.block_col;
      brow_q <= ctl_i.block_row;
      last_q <= ctl_i.last_block;
    end
  end

  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.ready    = !s1_valid_q || s1_move;
  assign out_valid_o     = out_valid_q;
  assign approx_o        = a_q;
  assign horiz_o         = h_q;
  assign vert_o          = v_q;
  assign diag_o          = g_q;
  assign block_col_o     = bcol_q;
  assign block_row_o     = brow_q;
  assign last_block_o    = last_q;

endmodule
